// ===== hdl/ipv4rhf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4rhf_pkg
// Shared types, verdict codes and header constants for the IPv4 receive
// header filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4rhf_pkg;

    // Verdict codes
    localparam logic [2:0] VERDICT_ICMP       = 3'd0;
    localparam logic [2:0] VERDICT_UDP        = 3'd1;
    localparam logic [2:0] VERDICT_TCP        = 3'd2;
    localparam logic [2:0] VERDICT_DROP_SHORT = 3'd3;
    localparam logic [2:0] VERDICT_DROP_CSUM  = 3'd4;
    localparam logic [2:0] VERDICT_DROP_ADDR  = 3'd5;
    localparam logic [2:0] VERDICT_DROP_PROTO = 3'd6;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Header layout
    localparam logic [5:0]  MIN_HEADER_BYTES = 6'd20;
    localparam logic [5:0]  POS_IHL          = 6'd0;
    localparam logic [5:0]  POS_TOTAL_HI     = 6'd2;
    localparam logic [5:0]  POS_TOTAL_LO     = 6'd3;
    localparam logic [5:0]  POS_PROTOCOL     = 6'd9;
    localparam logic [5:0]  POS_SOURCE_FIRST = 6'd12;
    localparam logic [5:0]  POS_SOURCE_LAST  = 6'd15;
    localparam logic [5:0]  POS_DEST_FIRST   = 6'd16;
    localparam logic [5:0]  POS_DEST_LAST    = 6'd19;
    localparam logic [5:0]  POS_MAX          = 6'd63;
    localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;
    localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;

    // One verdict as produced by the parser for the current byte
    typedef struct packed {
        logic        emit;
        logic [2:0]  verdict;
        logic [31:0] source_ip;
        logic [5:0]  header_bytes;
        logic [15:0] transport_length;
    } rhf_result_t;

endpackage : ipv4rhf_pkg

`default_nettype wire

// ===== hdl/ipv4rhf_if.sv =====
// ----------------------------------------------------------------------------
// ipv4rhf channel interfaces
// Valid/ready channels for packet bytes, verdicts and the address write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4rhf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : ipv4rhf_byte_if

interface ipv4rhf_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [31:0] source_ip;
    logic [5:0]  header_bytes;
    logic [15:0] transport_length;

    modport source (output valid, output verdict, output source_ip,
                    output header_bytes, output transport_length, input ready);
    modport sink   (input valid, input verdict, input source_ip,
                    input header_bytes, input transport_length, output ready);
endinterface : ipv4rhf_verdict_if

interface ipv4rhf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] local_address;

    modport source (output valid, output local_address, input ready);
    modport sink   (input valid, input local_address, output ready);
endinterface : ipv4rhf_cfg_if

`default_nettype wire

// ===== hdl/ipv4rhf_parse.sv =====
// ----------------------------------------------------------------------------
// ipv4rhf_parse
// Per-packet header state, checksum accumulation and verdict decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4rhf_parse
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step_en,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last_byte,
    input  wire logic [31:0]               local_address,
    output ipv4rhf_pkg::rhf_result_t       result
);
    import ipv4rhf_pkg::*;

    logic [5:0]  byte_index_reg,   byte_index_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [15:0] csum_reg,         csum_next;
    logic [7:0]  high_hold_reg,    high_hold_next;
    logic [15:0] total_len_reg,    total_len_next;
    logic [7:0]  protocol_reg,     protocol_next;
    logic [31:0] source_reg,       source_next;
    logic [31:0] dest_reg,         dest_next;
    logic        given_reg,        given_next;

    logic [5:0]  hdr_len;
    logic [5:0]  end_point;
    logic [16:0] csum_wide;
    logic        at_end;
    logic        dest_ok;

    always_comb
    begin
        header_words_next = (byte_index_reg == POS_IHL) ? data_byte[3:0] : header_words_reg;
        hdr_len           = {header_words_next, 2'b00};
        end_point         = (hdr_len > MIN_HEADER_BYTES) ? hdr_len : MIN_HEADER_BYTES;

        total_len_next = total_len_reg;
        protocol_next  = protocol_reg;
        source_next    = source_reg;
        dest_next      = dest_reg;
        if (byte_index_reg == POS_TOTAL_HI)
        begin
            total_len_next = {data_byte, total_len_reg[7:0]};
        end
        else if (byte_index_reg == POS_TOTAL_LO)
        begin
            total_len_next = {total_len_reg[15:8], data_byte};
        end
        else if (byte_index_reg == POS_PROTOCOL)
        begin
            protocol_next = data_byte;
        end
        else if (byte_index_reg >= POS_SOURCE_FIRST && byte_index_reg <= POS_SOURCE_LAST)
        begin
            source_next = {source_reg[23:0], data_byte};
        end
        else if (byte_index_reg >= POS_DEST_FIRST && byte_index_reg <= POS_DEST_LAST)
        begin
            dest_next = {dest_reg[23:0], data_byte};
        end

        // One's-complement add with a single end-around fold
        csum_wide      = {1'b0, csum_reg} + {1'b0, high_hold_reg, data_byte};
        csum_next      = csum_reg;
        high_hold_next = high_hold_reg;
        if (byte_index_reg < hdr_len)
        begin
            if (!byte_index_reg[0])
            begin
                high_hold_next = data_byte;
            end
            else
            begin
                csum_next = csum_wide[15:0] + {15'd0, csum_wide[16]};
            end
        end

        byte_index_next = (byte_index_reg < POS_MAX) ? byte_index_reg + 6'd1 : POS_MAX;
        at_end          = ({1'b0, byte_index_reg} + 7'd1) == {1'b0, end_point};
        dest_ok         = (dest_next == local_address) || (dest_next == BROADCAST_ADDR);

        result = '0;
        if (!given_reg && at_end)
        begin
            result.emit = 1'b1;
            if (csum_next != CSUM_GOOD)
            begin
                result.verdict = VERDICT_DROP_CSUM;
            end
            else if (!dest_ok)
            begin
                result.verdict = VERDICT_DROP_ADDR;
            end
            else if (protocol_next == PROTO_ICMP)
            begin
                result.verdict = VERDICT_ICMP;
            end
            else if (protocol_next == PROTO_UDP)
            begin
                result.verdict = VERDICT_UDP;
            end
            else if (protocol_next == PROTO_TCP)
            begin
                result.verdict = VERDICT_TCP;
            end
            else
            begin
                result.verdict = VERDICT_DROP_PROTO;
            end
            result.source_ip        = source_next;
            result.header_bytes     = hdr_len;
            result.transport_length = total_len_next - {10'd0, hdr_len};
        end
        else if (!given_reg && last_byte)
        begin
            result.emit    = 1'b1;
            result.verdict = VERDICT_DROP_SHORT;
        end

        given_next = given_reg | at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            header_words_reg <= '0;
            csum_reg         <= '0;
            high_hold_reg    <= '0;
            total_len_reg    <= '0;
            protocol_reg     <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
            given_reg        <= 1'b0;
        end
        else if (step_en)
        begin
            if (last_byte)
            begin
                // drop all packet state at the end of the packet
                byte_index_reg   <= '0;
                header_words_reg <= '0;
                csum_reg         <= '0;
                high_hold_reg    <= '0;
                total_len_reg    <= '0;
                protocol_reg     <= '0;
                source_reg       <= '0;
                dest_reg         <= '0;
                given_reg        <= 1'b0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                header_words_reg <= header_words_next;
                csum_reg         <= csum_next;
                high_hold_reg    <= high_hold_next;
                total_len_reg    <= total_len_next;
                protocol_reg     <= protocol_next;
                source_reg       <= source_next;
                dest_reg         <= dest_next;
                given_reg        <= given_next;
            end
        end
    end

endmodule : ipv4rhf_parse

`default_nettype wire

// ===== hdl/ipv4_receive_header_filter.sv =====
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// Byte-stream IPv4 header checker giving one verdict per packet.
// ----------------------------------------------------------------------------
// Usage:
//   packet : one byte per transfer, starting at the first IPv4 header byte;
//            last_byte marks the final byte of each packet.
//   result : one transfer per packet carrying the verdict, source address,
//            header length and transport length. It appears once the byte
//            completing max(20, IHL*4) header bytes is processed, or on the
//            last byte of a packet that ends sooner (drop short).
//   cfg    : writes local_address; write only while no packet is in flight.
// Path: a byte is captured in the input register at its transfer and is
//   processed as it leaves that register, which loads its verdict into the
//   result register that drives result.valid.
// Throughput: one byte per cycle while result is not stalled; the parse step
//   is combinational between the input register and the result register.
// Reset: clears the packet state, local_address and the valid flags of both registers.
// Stall: while a verdict waits on result with ready low, parsing holds; the
//   input register takes one more byte if it is empty, then packet.ready
//   drops until the verdict transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_receive_header_filter
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    ipv4rhf_byte_if.sink       packet,
    ipv4rhf_verdict_if.source  result,
    ipv4rhf_cfg_if.sink        cfg
);
    import ipv4rhf_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [2:0]  out_verdict_reg;
    logic [31:0] out_source_reg;
    logic [5:0]  out_hdr_reg;
    logic [15:0] out_transport_reg;

    logic [31:0] local_address_reg;

    logic        advance;
    logic        consume;
    rhf_result_t step_result;

    // Parse may run when the result register is free or being emptied
    assign advance = !out_valid_reg || result.ready;
    assign consume = in_valid_reg && advance;

    assign packet.ready = !in_valid_reg || consume;
    assign cfg.ready    = 1'b1;

    // Address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
        end
        else if (cfg.valid)
        begin
            local_address_reg <= cfg.local_address;
        end
    end

    // Input register: capture each byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (packet.ready)
        begin
            in_valid_reg <= packet.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            in_data_reg <= packet.data_byte;
            in_last_reg <= packet.last_byte;
        end
    end

    ipv4rhf_parse u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (consume),
        .data_byte     (in_data_reg),
        .last_byte     (in_last_reg),
        .local_address (local_address_reg),
        .result        (step_result)
    );

    // Result register: load a verdict, hold it until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && step_result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && step_result.emit)
        begin
            out_verdict_reg   <= step_result.verdict;
            out_source_reg    <= step_result.source_ip;
            out_hdr_reg       <= step_result.header_bytes;
            out_transport_reg <= step_result.transport_length;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.verdict          = out_verdict_reg;
    assign result.source_ip        = out_source_reg;
    assign result.header_bytes     = out_hdr_reg;
    assign result.transport_length = out_transport_reg;

endmodule : ipv4_receive_header_filter

`default_nettype wire

// ===== tb/tb_ipv4_receive_header_filter.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_receive_header_filter
// Self-checking bench for the IPv4 receive header filter. Sends IPv4 packets
// a byte per transfer, tracks the header in a local model of the parser, and
// compares every verdict transfer field by field against the queue of
// verdicts the model has worked out. Directed packets cover every verdict and
// header corner; random traffic follows under several local addresses.
// ----------------------------------------------------------------------------

module tb_ipv4_receive_header_filter;

    import ipv4rhf_pkg::*;

    // Pause after the last expected verdict before touching local_address
    // or ending the run: a byte that gives no verdict may still be in the
    // pipeline when the last verdict leaves.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] source_ip;
        logic [5:0]  header_bytes;
        logic [15:0] transport_length;
    } verdict_rec_t;

    logic clk;
    logic rst_n;

    ipv4rhf_byte_if    pkt_if ();
    ipv4rhf_verdict_if res_if ();
    ipv4rhf_cfg_if     cfg_if ();

    ipv4_receive_header_filter dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (pkt_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Header tracker: mirrors the parser state, advanced once per accepted
    // byte transfer.
    // ------------------------------------------------------------------------
    logic [31:0] host_addr;
    logic [5:0]  hdr_pos;
    logic [3:0]  hdr_words;
    logic [15:0] ones_sum;
    logic [7:0]  hi_byte;
    logic [15:0] total_len;
    logic [7:0]  proto_num;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        verdict_sent;

    verdict_rec_t pending_verdicts[$];

    logic [7:0] frame_q[$];
    bit         idle_off;
    int         bytes_sent;
    int         verdicts_predicted;
    int         mismatch_count;

    function automatic void clear_header_state();
        hdr_pos      = '0;
        hdr_words    = '0;
        ones_sum     = '0;
        hi_byte      = '0;
        total_len    = '0;
        proto_num    = '0;
        src_addr     = '0;
        dst_addr     = '0;
        verdict_sent = 1'b0;
    endfunction

    function automatic void track_header_byte(input logic [7:0] d, input logic is_last);
        logic [5:0]   hdr_len;
        logic [5:0]   end_pt;
        logic [16:0]  s;
        logic         at_end;
        verdict_rec_t r;

        if (hdr_pos == POS_IHL)
            hdr_words = d[3:0];
        hdr_len = {hdr_words, 2'b00};

        if (hdr_pos == POS_TOTAL_HI)
            total_len[15:8] = d;
        else if (hdr_pos == POS_TOTAL_LO)
            total_len[7:0] = d;
        else if (hdr_pos == POS_PROTOCOL)
            proto_num = d;
        else if (hdr_pos >= POS_SOURCE_FIRST && hdr_pos <= POS_SOURCE_LAST)
            src_addr = {src_addr[23:0], d};
        else if (hdr_pos >= POS_DEST_FIRST && hdr_pos <= POS_DEST_LAST)
            dst_addr = {dst_addr[23:0], d};

        // Sum 16-bit words over IHL*4 bytes with end-around carry
        if (hdr_pos < hdr_len)
        begin
            if (!hdr_pos[0])
                hi_byte = d;
            else
            begin
                s = {1'b0, ones_sum} + {1'b0, hi_byte, d};
                s = {1'b0, s[15:0]} + {16'd0, s[16]};
                ones_sum = s[15:0];
            end
        end

        end_pt = (hdr_len > MIN_HEADER_BYTES) ? hdr_len : MIN_HEADER_BYTES;
        at_end = ({1'b0, hdr_pos} + 7'd1) == {1'b0, end_pt};
        if (hdr_pos != POS_MAX)
            hdr_pos = hdr_pos + 6'd1;

        if (!verdict_sent && at_end)
        begin
            if (ones_sum != CSUM_GOOD)
                r.verdict = VERDICT_DROP_CSUM;
            else if (dst_addr != host_addr && dst_addr != BROADCAST_ADDR)
                r.verdict = VERDICT_DROP_ADDR;
            else if (proto_num == PROTO_ICMP)
                r.verdict = VERDICT_ICMP;
            else if (proto_num == PROTO_UDP)
                r.verdict = VERDICT_UDP;
            else if (proto_num == PROTO_TCP)
                r.verdict = VERDICT_TCP;
            else
                r.verdict = VERDICT_DROP_PROTO;
            r.source_ip        = src_addr;
            r.header_bytes     = hdr_len;
            r.transport_length = total_len - {10'd0, hdr_len};
            pending_verdicts.push_back(r);
            verdicts_predicted++;
            verdict_sent = 1'b1;
        end
        else if (!verdict_sent && is_last)
        begin
            r = '0;
            r.verdict = VERDICT_DROP_SHORT;
            pending_verdicts.push_back(r);
            verdicts_predicted++;
        end

        if (is_last)
            clear_header_state();
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (idle_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Verdict side: compare each transfer with the oldest pending verdict,
    // then pick the ready pattern for the next cycle.
    // ------------------------------------------------------------------------
    initial
    begin : verdict_monitor
        verdict_rec_t seen;
        verdict_rec_t want;
        int unsigned  stall_left;

        res_if.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                seen.verdict          = res_if.verdict;
                seen.source_ip        = res_if.source_ip;
                seen.header_bytes     = res_if.header_bytes;
                seen.transport_length = res_if.transport_length;
                if (pending_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("verdict transfer with none pending: verdict %0d src %h hdr %0d len %0d",
                                 seen.verdict, seen.source_ip, seen.header_bytes,
                                 seen.transport_length);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (seen.verdict !== want.verdict || seen.source_ip !== want.source_ip ||
                        seen.header_bytes !== want.header_bytes ||
                        seen.transport_length !== want.transport_length)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("verdict mismatch at %0t", $realtime);
                            $display("  expected verdict %0d src %h hdr %0d len %0d",
                                     want.verdict, want.source_ip, want.header_bytes,
                                     want.transport_length);
                            $display("  actual   verdict %0d src %h hdr %0d len %0d",
                                     seen.verdict, seen.source_ip, seen.header_bytes,
                                     seen.transport_length);
                        end
                    end
                end
            end
            // Hold ready low through a stall, else raise it and draw the next
            if (stall_left != 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one byte. Valid stays high after the transfer so that a following
    // byte with no gap goes out on the very next cycle; drop it only when a
    // gap is drawn or the stream pauses.
    task automatic send_byte(input logic [7:0] d, input logic is_last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            pkt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.data_byte <= d;
        pkt_if.last_byte <= is_last;
        do
            @(posedge clk);
        while (!pkt_if.ready);
        track_header_byte(d, is_last);
        bytes_sent++;
    endtask

    // Send the first count bytes of the frame, the last of them flagged
    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++)
            send_byte(frame_q[i], i == count - 1);
    endtask

    // Pause the stream, let all pending verdicts leave, then let the pipe empty
    task automatic settle();
        pkt_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local_address(input logic [31:0] addr);
        settle();
        cfg_if.valid         <= 1'b1;
        cfg_if.local_address <= addr;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        host_addr = addr;
    endtask

    // Build a header of max(20, IHL*4) random bytes with the given fields,
    // then append the payload. With good_csum the checksum field is fixed so
    // the one's-complement sum over IHL*4 >= 12 bytes is all ones; without it one bit is off.
    task automatic build_frame(input logic [3:0] ihl, input logic [15:0] total,
                               input logic [7:0] proto, input logic [31:0] src,
                               input logic [31:0] dst, input bit good_csum,
                               input int payload);
        int          hlen;
        logic [3:0]  ver;
        logic [15:0] acc;
        logic [15:0] field;
        logic [16:0] s;

        frame_q.delete();
        hlen = (int'(ihl) * 4 < 20) ? 20 : int'(ihl) * 4;
        for (int i = 0; i < hlen; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
        ver = 4'($urandom_range(0, 15));
        frame_q[0]  = {ver, ihl};
        frame_q[2]  = total[15:8];
        frame_q[3]  = total[7:0];
        frame_q[9]  = proto;
        frame_q[10] = 8'h00;
        frame_q[11] = 8'h00;
        for (int i = 0; i < 4; i++)
        begin
            frame_q[12 + i] = src[31 - 8 * i -: 8];
            frame_q[16 + i] = dst[31 - 8 * i -: 8];
        end
        acc = '0;
        for (int i = 0; i + 1 < int'(ihl) * 4; i += 2)
        begin
            s   = {1'b0, acc} + {1'b0, frame_q[i], frame_q[i + 1]};
            acc = s[15:0] + {15'd0, s[16]};
        end
        field = good_csum ? ~acc : ~acc ^ (16'd1 << $urandom_range(0, 15));
        frame_q[10] = field[15:8];
        frame_q[11] = field[7:0];
        for (int i = 0; i < payload; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Whole packet with a consistent total length and random source
    task automatic send_header(input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [31:0] dst, input bit good_csum,
                               input int payload);
        build_frame(ihl, 16'(int'(ihl) * 4 + payload), proto, $urandom, dst,
                    good_csum, payload);
        send_frame(frame_q.size());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // local_address comes out of reset as zero
    task automatic test_reset_address();
        send_header(4'd5, PROTO_ICMP, 32'h0000_0000, 1'b1, 0);
        send_header(4'd5, PROTO_UDP, 32'h0000_0001, 1'b1, 2);
    endtask

    task automatic test_protocol_classes();
        write_local_address(32'hC0A8_0A01);
        send_header(4'd5, PROTO_ICMP, host_addr, 1'b1, 1);
        send_header(4'd5, PROTO_UDP, host_addr, 1'b1, 3);
        send_header(4'd5, PROTO_TCP, host_addr, 1'b1, 0);
        send_header(4'd5, 8'h00, host_addr, 1'b1, 0);
        send_header(4'd5, 8'hFF, host_addr, 1'b1, 0);
        send_header(4'd5, PROTO_UDP, BROADCAST_ADDR, 1'b1, 1);
    endtask

    task automatic test_drop_reasons();
        send_header(4'd5, PROTO_TCP, host_addr, 1'b0, 0);
        send_header(4'd5, PROTO_TCP, 32'h0A00_0001, 1'b1, 0);
        // one-byte packet
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame(1);
        // packet ending one byte before the verdict point
        build_frame(4'd5, 16'd20, PROTO_UDP, $urandom, host_addr, 1'b1, 0);
        send_frame(19);
        // IHL zero sums nothing; IHL three sums only part of the header
        send_header(4'd0, PROTO_ICMP, host_addr, 1'b1, 0);
        send_header(4'd3, PROTO_ICMP, host_addr, 1'b1, 2);
    endtask

    task automatic test_header_lengths();
        send_header(4'd15, PROTO_UDP, host_addr, 1'b1, 2);
        build_frame(4'd15, 16'd60, PROTO_UDP, $urandom, host_addr, 1'b1, 0);
        send_frame(59);
        // last byte lands on the verdict byte
        send_header(4'd6, PROTO_TCP, host_addr, 1'b1, 0);
        // total length below the header length wraps; all-ones total
        build_frame(4'd5, 16'h0000, PROTO_ICMP, $urandom, host_addr, 1'b1, 1);
        send_frame(frame_q.size());
        build_frame(4'd5, 16'hFFFF, PROTO_ICMP, $urandom, host_addr, 1'b1, 1);
        send_frame(frame_q.size());
        // long packet drives the byte counter into saturation
        send_header(4'd5, PROTO_UDP, host_addr, 1'b1, 60);
    endtask

    task automatic test_byte_extremes();
        // all ones: IHL 15, sum all ones, broadcast, protocol 255
        frame_q.delete();
        repeat (60) frame_q.push_back(8'hFF);
        send_frame(frame_q.size());
        // all zeros: IHL zero, verdict at byte 20, trailing bytes ignored
        frame_q.delete();
        repeat (24) frame_q.push_back(8'h00);
        send_frame(frame_q.size());
    endtask

    task automatic test_broadcast_local();
        write_local_address(BROADCAST_ADDR);
        send_header(4'd5, PROTO_TCP, BROADCAST_ADDR, 1'b1, 0);
        send_header(4'd5, PROTO_TCP, 32'h7F00_0001, 1'b1, 0);
    endtask

    // Mostly well-formed packets with random content, some malformed headers
    // and some plain noise. Runs until both the byte goal and the verdict
    // goal are met.
    task automatic test_random_traffic(input int byte_goal, input int verdict_goal,
                                       input bit quiet);
        int          start_bytes;
        int          start_verdicts;
        int          payload;
        int          count;
        int unsigned roll;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [15:0] total;

        start_bytes    = bytes_sent;
        start_verdicts = verdicts_predicted;
        while (bytes_sent - start_bytes < byte_goal ||
               verdicts_predicted - start_verdicts < verdict_goal)
        begin
            idle_off = quiet || ($urandom_range(0, 5) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 72)
            begin
                ihl = ($urandom_range(0, 2) != 0) ? 4'd5 : 4'($urandom_range(6, 15));
                case ($urandom_range(0, 4))
                    0:       proto = PROTO_ICMP;
                    1:       proto = PROTO_UDP;
                    2:       proto = PROTO_TCP;
                    default: proto = 8'($urandom_range(0, 255));
                endcase
                roll = $urandom_range(0, 99);
                dst  = (roll < 50) ? host_addr : (roll < 65) ? BROADCAST_ADDR : $urandom;
                payload = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 6);
                total = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'(int'(ihl) * 4 + payload);
                build_frame(ihl, total, proto, $urandom, dst,
                            $urandom_range(0, 9) != 0, payload);
                count = frame_q.size();
                if ($urandom_range(0, 9) == 0)
                    count = $urandom_range(1, count);
                send_frame(count);
            end
            else if (roll < 86)
            begin
                build_frame(4'($urandom_range(0, 4)), 16'($urandom), 8'($urandom),
                            $urandom, host_addr, $urandom_range(0, 1),
                            $urandom_range(0, 4));
                send_frame(frame_q.size());
            end
            else
            begin
                frame_q.delete();
                repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
                send_frame(frame_q.size());
            end
        end
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;

        rst_n                <= 1'b0;
        pkt_if.valid         <= 1'b0;
        pkt_if.data_byte     <= 8'h00;
        pkt_if.last_byte     <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.local_address <= 32'h0;
        host_addr          = '0;
        idle_off           = 1'b0;
        bytes_sent         = 0;
        verdicts_predicted = 0;
        mismatch_count     = 0;
        clear_header_state();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_address();
        test_protocol_classes();
        test_drop_reasons();
        test_header_lengths();
        test_byte_extremes();
        test_broadcast_local();

        write_local_address($urandom);
        test_random_traffic(100, 3, 1'b0);
        write_local_address(BROADCAST_ADDR);
        test_random_traffic(100, 3, 1'b0);
        write_local_address(32'h0000_0000);
        test_random_traffic(100, 3, 1'b0);
        write_local_address($urandom);
        test_random_traffic(100, 3, 1'b1);

        // Drain: wait for the last verdicts, bounded, then count leftovers
        pkt_if.valid <= 1'b0;
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatch_count += pending_verdicts.size();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
